// ===== rtl/gtus_pkg.sv =====
// Package for the grid to unit sphere point block: CORDIC constants and shared types.
// Depends on nothing; used by every module in rtl.
package gtus_pkg;
    localparam int STEP_WIDTH   = 11;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_WIDTH    = 26;
    localparam int VEC_WIDTH    = 34;
    localparam logic signed [VEC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_WIDTH-1:0] QUARTER_TURN = 26'sd4194304;
    localparam logic signed [ANG_WIDTH-1:0] HALF_TURN    = 26'sd8388608;

    localparam logic [1:0] ADDR_LAT_STEPS  = 2'd0;
    localparam logic [1:0] ADDR_LONG_STEPS = 2'd1;

    function automatic logic signed [ANG_WIDTH-1:0] atan_turn(input int i);
        logic signed [ANG_WIDTH-1:0] a;
        begin
            unique case (i)
                0: a = 26'sd2097152;   1: a = 26'sd1238021;
                2: a = 26'sd654136;    3: a = 26'sd332051;
                4: a = 26'sd166669;    5: a = 26'sd83416;
                6: a = 26'sd41718;     7: a = 26'sd20860;
                8: a = 26'sd10430;     9: a = 26'sd5215;
                10: a = 26'sd2608;     11: a = 26'sd1304;
                12: a = 26'sd652;      13: a = 26'sd326;
                14: a = 26'sd163;      default: a = 26'sd81;
            endcase
            return a;
        end
    endfunction
endpackage

// ===== rtl/grid_to_unit_sphere_point.sv =====
// Top level of the grid to unit sphere point block: APB registers, divider and
// CORDIC cell chains, product stage and output skid. Depends on gtus_pkg and the cells.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------
//  input   | i_valid o_ready i_lat_index i_long_index  | one grid point item
//  output  | o_valid i_ready o_x/y/z_coord o_out_of_range | one point item
//  config  | psel penable pwrite paddr pwdata prdata pready | step registers
//
// An item is accepted every cycle while the pipeline advances. From the accepting
// edge to the first edge at which the result can be taken it passes a 16-cell restoring
// divider chain (one quotient bit per cell), the range fold, a 16-cell CORDIC chain,
// the rounding stage, the product stage and the output skid register.
// The whole pipeline advances while its last stage is empty, the skid has room or
// the skid is being emptied; the two-entry skid lets the chain run on after a stall.
// Reset (synchronous, active low) clears valid bits and sets both steps to 10.
module grid_to_unit_sphere_point
    import gtus_pkg::*;
#(
    parameter int INDEX_WIDTH = 10,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [INDEX_WIDTH-1:0]        i_lat_index,
    input  logic [INDEX_WIDTH-1:0]        i_long_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_x_coord,
    output logic signed [COORD_WIDTH-1:0] o_y_coord,
    output logic signed [COORD_WIDTH-1:0] o_z_coord,
    output logic                          o_out_of_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int FRAC     = COORD_WIDTH - 1;
    localparam int NUM_W    = INDEX_WIDTH + 16;
    localparam int DIV_N    = 16;
    localparam int DEPTH    = DIV_N + 1 + CORDIC_STEPS + 2;
    localparam int SH       = 30 - FRAC;
    localparam logic signed [VEC_WIDTH-1:0] HALF_Q = VEC_WIDTH'(1) <<< (SH - 1);
    localparam logic signed [2*COORD_WIDTH-1:0] CMAX = (2*COORD_WIDTH)'((1 << FRAC) - 1);

    // Configuration registers.
    logic [STEP_WIDTH-1:0] r_lat_steps;
    logic [STEP_WIDTH-1:0] r_long_steps;
    logic                  w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_steps  <= STEP_WIDTH'(10);
            r_long_steps <= STEP_WIDTH'(10);
        end else if (w_wr) begin
            if (paddr[2:2] == ADDR_LAT_STEPS[0:0] && paddr[1:0] == 2'b00)
                r_lat_steps <= pwdata[STEP_WIDTH-1:0];
            if (paddr[2:2] == ADDR_LONG_STEPS[0:0] && paddr[1:0] == 2'b00)
                r_long_steps <= pwdata[STEP_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == ADDR_LAT_STEPS[0])
                prdata[STEP_WIDTH-1:0] = r_lat_steps;
            else
                prdata[STEP_WIDTH-1:0] = r_long_steps;
        end
    end

    // Pipeline advance and valid bits; out-of-range flag rides alongside.
    logic             w_adv;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_oor;
    logic             w_in_oor;
    logic             w_fire;
    logic [1:0]       r_cnt;

    // A step count of zero makes every index out of range.
    assign w_in_oor = (32'(i_lat_index) >= 32'(r_lat_steps)) ||
                      (32'(i_long_index) >= 32'(r_long_steps));
    // Advance unless an item in the last stage would meet a full skid that is not
    // being emptied in the same cycle.
    assign w_adv   = !r_vld[DEPTH-1] || (r_cnt != 2'd2) || i_ready;
    assign o_ready = w_adv;
    assign w_fire  = i_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], w_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_oor <= {r_oor[DEPTH-2:0], w_in_oor};
    end

    // Divider chains: lat*2^15/lat_steps and lon*2^16/long_steps.
    logic [STEP_WIDTH:0]   w_ra [DIV_N+1];
    logic [NUM_W-1:0]      w_na [DIV_N+1];
    logic [STEP_WIDTH-1:0] w_da [DIV_N+1];
    logic [STEP_WIDTH:0]   w_rb [DIV_N+1];
    logic [NUM_W-1:0]      w_nb [DIV_N+1];
    logic [STEP_WIDTH-1:0] w_db [DIV_N+1];

    // Each index starts as the remainder; for an index below its step count the
    // chain yields index*2^16/steps. The latitude quotient is halved afterwards.
    assign w_ra[0] = (STEP_WIDTH+1)'(i_lat_index);
    assign w_na[0] = '0;
    assign w_da[0] = (r_lat_steps == '0) ? STEP_WIDTH'(1) : r_lat_steps;
    assign w_rb[0] = (STEP_WIDTH+1)'(i_long_index);
    assign w_nb[0] = '0;
    assign w_db[0] = (r_long_steps == '0) ? STEP_WIDTH'(1) : r_long_steps;

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        gtus_div_cell #(.NUM_WIDTH(NUM_W)) u_lat (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_ra[g]), .i_num(w_na[g]), .i_den(w_da[g]),
            .o_rem(w_ra[g+1]), .o_num(w_na[g+1]), .o_den(w_da[g+1])
        );
        gtus_div_cell #(.NUM_WIDTH(NUM_W)) u_lon (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_rb[g]), .i_num(w_nb[g]), .i_den(w_db[g]),
            .o_rem(w_rb[g+1]), .o_num(w_nb[g+1]), .o_den(w_db[g+1])
        );
    end

    // Angle fold into +-quarter turn.
    logic signed [ANG_WIDTH-1:0] r_tp, r_ta;
    logic                        r_fp, r_fa;

    function automatic logic [ANG_WIDTH:0] fold(input logic [15:0] a16);
        logic signed [ANG_WIDTH-1:0] t;
        logic                        f;
        begin
            t = $signed({2'b00, a16, 8'h00});
            if (t >= HALF_TURN) t = t - (HALF_TURN <<< 1);
            f = 1'b0;
            if (t > QUARTER_TURN) begin
                t = t - HALF_TURN; f = 1'b1;
            end else if (t < -QUARTER_TURN) begin
                t = t + HALF_TURN; f = 1'b1;
            end
            return {f, t};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            {r_fp, r_tp} <= fold({1'b0, w_na[DIV_N][15:1]});
            {r_fa, r_ta} <= fold(w_nb[DIV_N][15:0]);
        end
    end

    // CORDIC chains with flip flags carried along.
    logic signed [VEC_WIDTH-1:0] w_xp [CORDIC_STEPS+1];
    logic signed [VEC_WIDTH-1:0] w_yp [CORDIC_STEPS+1];
    logic signed [ANG_WIDTH-1:0] w_tp [CORDIC_STEPS+1];
    logic signed [VEC_WIDTH-1:0] w_xa [CORDIC_STEPS+1];
    logic signed [VEC_WIDTH-1:0] w_ya [CORDIC_STEPS+1];
    logic signed [ANG_WIDTH-1:0] w_ta [CORDIC_STEPS+1];
    logic [CORDIC_STEPS-1:0]     r_flp, r_fla;

    assign w_xp[0] = CORDIC_GAIN;
    assign w_yp[0] = '0;
    assign w_tp[0] = r_tp;
    assign w_xa[0] = CORDIC_GAIN;
    assign w_ya[0] = '0;
    assign w_ta[0] = r_ta;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
        gtus_cordic_cell #(.SHIFT(g)) u_p (
            .i_clk(i_clk), .i_en(w_adv),
            .i_x(w_xp[g]), .i_y(w_yp[g]), .i_t(w_tp[g]),
            .o_x(w_xp[g+1]), .o_y(w_yp[g+1]), .o_t(w_tp[g+1])
        );
        gtus_cordic_cell #(.SHIFT(g)) u_a (
            .i_clk(i_clk), .i_en(w_adv),
            .i_x(w_xa[g]), .i_y(w_ya[g]), .i_t(w_ta[g]),
            .o_x(w_xa[g+1]), .o_y(w_ya[g+1]), .o_t(w_ta[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flp <= {r_flp[CORDIC_STEPS-2:0], r_fp};
            r_fla <= {r_fla[CORDIC_STEPS-2:0], r_fa};
        end
    end

    // Rounding to Q1.F with saturation.
    function automatic logic signed [COORD_WIDTH-1:0] to_coord(
        input logic signed [VEC_WIDTH-1:0] v, input logic f);
        logic signed [VEC_WIDTH-1:0] n;
        logic signed [VEC_WIDTH-1:0] s;
        begin
            n = f ? -v : v;
            s = (n + HALF_Q) >>> SH;
            if (s > VEC_WIDTH'(CMAX)) s = VEC_WIDTH'(CMAX);
            else if (s < -VEC_WIDTH'(CMAX)) s = -VEC_WIDTH'(CMAX);
            return s[COORD_WIDTH-1:0];
        end
    endfunction

    logic signed [COORD_WIDTH-1:0] r_sp, r_cp, r_sa, r_ca;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sp <= to_coord(w_yp[CORDIC_STEPS], r_flp[CORDIC_STEPS-1]);
            r_cp <= to_coord(w_xp[CORDIC_STEPS], r_flp[CORDIC_STEPS-1]);
            r_sa <= to_coord(w_ya[CORDIC_STEPS], r_fla[CORDIC_STEPS-1]);
            r_ca <= to_coord(w_xa[CORDIC_STEPS], r_fla[CORDIC_STEPS-1]);
        end
    end

    // Products, rounding and the out-of-range zeroing.
    function automatic logic signed [COORD_WIDTH-1:0] mul_c(
        input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
        logic signed [2*COORD_WIDTH-1:0] p;
        begin
            p = ((2*COORD_WIDTH)'(a) * (2*COORD_WIDTH)'(b) +
                 ((2*COORD_WIDTH)'(1) <<< (FRAC - 1))) >>> FRAC;
            if (p > CMAX) p = CMAX;
            else if (p < -CMAX) p = -CMAX;
            return p[COORD_WIDTH-1:0];
        end
    endfunction

    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x <= r_oor[DEPTH-2] ? '0 : mul_c(r_sp, r_ca);
            r_y <= r_oor[DEPTH-2] ? '0 : mul_c(r_sp, r_sa);
            r_z <= r_oor[DEPTH-2] ? '0 : r_cp;
        end
    end

    // Output skid of two entries, written from the last stage.
    logic [3*COORD_WIDTH:0] r_q [2];
    logic                   w_push, w_pop;
    logic                   w_to_head;

    assign w_push = w_adv && r_vld[DEPTH-1];
    assign w_pop  = o_valid && i_ready;
    assign o_valid = r_cnt != 2'd0;
    assign {o_out_of_range, o_x_coord, o_y_coord, o_z_coord} = r_q[0];
    // A new item goes straight to the head when the skid is empty after this cycle's pop.
    assign w_to_head = w_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_to_head)
            r_q[0] <= {r_oor[DEPTH-1], r_x, r_y, r_z};
        else if (w_pop)
            r_q[0] <= r_q[1];
        if (w_push && !w_to_head)
            r_q[1] <= {r_oor[DEPTH-1], r_x, r_y, r_z};
    end
endmodule

// ===== rtl/gtus_div_cell.sv =====
// One restoring division cell: produces one quotient bit per stage.
// Depends on gtus_pkg.
module gtus_div_cell
    import gtus_pkg::*;
#(
    parameter int NUM_WIDTH = 26
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [STEP_WIDTH:0]   i_rem,
    input  logic [NUM_WIDTH-1:0]  i_num,
    input  logic [STEP_WIDTH-1:0] i_den,
    output logic [STEP_WIDTH:0]   o_rem,
    output logic [NUM_WIDTH-1:0]  o_num,
    output logic [STEP_WIDTH-1:0] o_den
);
    logic [STEP_WIDTH+1:0] w_trial;
    logic [STEP_WIDTH+1:0] w_diff;

    assign w_trial = {i_rem, i_num[NUM_WIDTH-1]};
    assign w_diff  = w_trial - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // While the incoming remainder is below the divisor it stays so, and fits STEP_WIDTH+1 bits.
            if (!w_diff[STEP_WIDTH+1]) begin
                o_rem <= w_diff[STEP_WIDTH:0];
                o_num <= {i_num[NUM_WIDTH-2:0], 1'b1};
            end else begin
                o_rem <= w_trial[STEP_WIDTH:0];
                o_num <= {i_num[NUM_WIDTH-2:0], 1'b0};
            end
            o_den <= i_den;
        end
    end
endmodule

// ===== rtl/gtus_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed shift, registered outputs.
// Depends on gtus_pkg.
module gtus_cordic_cell
    import gtus_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [VEC_WIDTH-1:0] i_x,
    input  logic signed [VEC_WIDTH-1:0] i_y,
    input  logic signed [ANG_WIDTH-1:0] i_t,
    output logic signed [VEC_WIDTH-1:0] o_x,
    output logic signed [VEC_WIDTH-1:0] o_y,
    output logic signed [ANG_WIDTH-1:0] o_t
);
    logic signed [VEC_WIDTH-1:0] w_dx;
    logic signed [VEC_WIDTH-1:0] w_dy;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_t[ANG_WIDTH-1]) begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_t <= i_t - atan_turn(SHIFT);
            end else begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_t <= i_t + atan_turn(SHIFT);
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for grid_to_unit_sphere_point: directed and random grid points checked
// against a fixed-point predictor built in here. Depends on gtus_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import gtus_pkg::*;

    localparam int IW = 10;
    localparam int CW = 16;
    localparam int FB = CW - 1;
    localparam longint CMAX = (64'sd1 <<< FB) - 1;
    localparam longint TURN = 64'sd1 <<< 24;
    localparam int LATENCY = 40;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [IW-1:0] lat;
        logic [IW-1:0] lon;
    } grid_item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 oor;
    } point_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [IW-1:0] i_lat_index = '0;
    logic [IW-1:0] i_long_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [CW-1:0] o_x_coord, o_y_coord, o_z_coord;
    logic o_out_of_range;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    grid_to_unit_sphere_point u_dut (.*);

    // The clock runs at 100 MHz.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grid_item_t pending_points[$];
    point_t     expected_points[$];
    logic [10:0] lat_steps_q = 11'd10;
    logic [10:0] long_steps_q = 11'd10;
    int  fail_count = 0;
    int  points_checked = 0;
    int  oor_seen = 0;
    bit  quiet_tail = 1'b0;
    int  hold_off = 0;
    longint cycle_count = 0;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < -CMAX) return -CMAX;
        return v;
    endfunction

    function automatic longint q30_round(longint v);
        int sh;
        sh = 30 - FB;
        return clamp_coord(floor_shr(v + (64'sd1 <<< (sh - 1)), sh));
    endfunction

    // Rotation of the gain vector by a 16-bit turn fraction; sine and cosine out.
    task automatic rotate_turn(input longint a16, output longint s, output longint c);
        longint t, x, y, dx, dy;
        bit flip;
        t = (a16 & 64'hFFFF) <<< 8;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (t >= TURN / 2) t -= TURN;
        if (t > TURN / 4) begin
            t -= TURN / 2;
            flip = 1'b1;
        end else if (t < -(TURN / 4)) begin
            t += TURN / 2;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (t >= 0) begin
                x -= dx;
                y += dy;
                t -= longint'(atan_turn(i));
            end else begin
                x += dx;
                y -= dy;
                t += longint'(atan_turn(i));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = q30_round(y);
        c = q30_round(x);
    endtask

    function automatic longint scale_product(longint a, longint b);
        return clamp_coord(floor_shr(a * b + (64'sd1 <<< (FB - 1)), FB));
    endfunction

    task automatic predict_point(input grid_item_t g);
        point_t p;
        longint sp, cp, sa, ca;
        p = '0;
        if (g.lat >= lat_steps_q || g.lon >= long_steps_q) begin
            p.oor = 1'b1;
        end else begin
            rotate_turn((longint'(g.lat) <<< 15) / lat_steps_q, sp, cp);
            rotate_turn((longint'(g.lon) <<< 16) / long_steps_q, sa, ca);
            p.x = CW'(scale_product(sp, ca));
            p.y = CW'(scale_product(sp, sa));
            p.z = CW'(cp);
        end
        expected_points = {expected_points, p};
    endtask

    // Appends one grid point to the sender's queue.
    task automatic queue_point(input logic [IW-1:0] la, input logic [IW-1:0] lo);
        grid_item_t g;
        g.lat = la;
        g.lon = lo;
        pending_points = {pending_points, g};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (point %0d)",
                 what, got, want, points_checked);
        fail_count++;
    endtask

    // Acceptance as seen at the last rising edge, used by the driver.
    bit o_ready_seen = 1'b0;

    // Driver: inputs move at the falling edge. The expectation is formed when
    // the item is seen accepted, so the predictor always uses the current steps.
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    i_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    grid_item_t g;
                    g = pending_points.pop_front();
                    i_lat_index <= g.lat;
                    i_long_index <= g.lon;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        o_ready_seen <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            predict_point('{lat: i_lat_index, lon: i_long_index});
    end

    // Receiver: random stall bursts, plus one long hold-off when asked for.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!quiet_tail && i_rst_n && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n;
        end
    end

    // Monitor: each accepted result is matched with the oldest expectation.
    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
            end else begin
                want = expected_points.pop_front();
                if (o_out_of_range !== want.oor)
                    report_mismatch("out_of_range", o_out_of_range, want.oor);
                if (o_x_coord !== want.x) report_mismatch("x_coord", o_x_coord, want.x);
                if (o_y_coord !== want.y) report_mismatch("y_coord", o_y_coord, want.y);
                if (o_z_coord !== want.z) report_mismatch("z_coord", o_z_coord, want.z);
                if (want.oor) oor_seen++;
                points_checked++;
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] reg_index, input logic [10:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 1'b0} << 1;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_index == ADDR_LAT_STEPS) lat_steps_q = value;
        else if (reg_index == ADDR_LONG_STEPS) long_steps_q = value;
    endtask

    task automatic drain_points();
        while (pending_points.size() > 0 || i_valid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [IW-1:0] pick_index(input logic [10:0] steps);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return IW'($urandom);
        if (r == 1 && steps <= 1024) return IW'(steps);
        if (steps == 0 || steps > 1024) return IW'($urandom);
        return IW'($urandom_range(0, steps - 1));
    endfunction

    task automatic queue_random(input int n, input logic [10:0] la, input logic [10:0] lo);
        for (int i = 0; i < n; i++)
            queue_point(pick_index(la), pick_index(lo));
    endtask

    initial begin
        logic [10:0] la, lo;
        logic [10:0] lat_set[6] = '{11'd1, 11'd1024, 11'd7, 11'd0, 11'd360, 11'd1023};
        logic [10:0] lon_set[6] = '{11'd1024, 11'd1, 11'd12, 11'd5, 11'd0, 11'd2047};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset steps first: corners, both limits and the out-of-range cases.
        queue_point(0, 0);
        queue_point(9, 9);
        queue_point(5, 0);
        queue_point(10, 0);
        queue_point(0, 10);
        queue_point(1023, 1023);
        queue_point(5, 5);
        queue_point(2, 7);
        drain_points();

        apb_write(ADDR_LAT_STEPS, 11'd1024);
        apb_write(ADDR_LONG_STEPS, 11'd1024);
        queue_point(1023, 1023);
        queue_point(512, 256);
        queue_point(256, 768);
        queue_point(10'h155, 10'h2AA);
        queue_point(10'h2AA, 10'h155);
        queue_point(1, 1);
        drain_points();

        queue_point(1000, 3);
        drain_points();

        // Long receiver hold-off while the sender keeps offering points.
        queue_random(120, lat_steps_q, long_steps_q);
        hold_off = 300;
        drain_points();

        for (int ph = 0; ph < 6; ph++) begin
            la = lat_set[ph];
            lo = lon_set[ph];
            apb_write(ADDR_LAT_STEPS, la);
            apb_write(ADDR_LONG_STEPS, lo);
            queue_random(200, la, lo);
            drain_points();
        end
        la = 11'($urandom_range(1, 1024));
        lo = 11'($urandom_range(1, 1024));
        apb_write(ADDR_LAT_STEPS, la);
        apb_write(ADDR_LONG_STEPS, lo);
        queue_random(300, la, lo);
        drain_points();

        // Final stretch with no idling on either side.
        quiet_tail = 1'b1;
        queue_random(200, la, lo);
        drain_points();

        $display("Checked %0d points over nine step settings, %0d of them out of range.",
                 points_checked, oor_seen);
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/gtus_pkg.sv
rtl/gtus_div_cell.sv
rtl/gtus_cordic_cell.sv
rtl/grid_to_unit_sphere_point.sv
tb/sv/tb.sv
